/* design/dlcf_pkg.sv */
// shared types, codes and sizes of the diff line classifier
package dlcf_pkg;

  // usable part of a line is LINE_PREFIX_BYTES-1 bytes
  localparam int LINE_PREFIX_BYTES = 16;
  localparam int CNT_W             = $clog2(LINE_PREFIX_BYTES);
  localparam int PREFIX_DEPTH      = 7;
  localparam int PFX_IDX_W         = $clog2(PREFIX_DEPTH);
  localparam int NUM_START_POS     = 4;

  localparam int LEVEL_W = 14;
  localparam logic [LEVEL_W-1:0] LEVEL_BASE   = 14'h0400;
  localparam logic [LEVEL_W-1:0] LEVEL_HEADER = 14'h2000;
  localparam logic [LEVEL_W-1:0] LEVEL_NUMBER = 14'h0FFF;
  localparam logic [LEVEL_W-1:0] LEVEL_RESET  = 14'h0400;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FOLD_ENABLE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_LEVEL = 1'b1;

  typedef enum logic [3:0] {
    CLS_DEFAULT      = 4'd0,
    CLS_COMMENT      = 4'd1,
    CLS_COMMAND      = 4'd2,
    CLS_HEADER       = 4'd3,
    CLS_POSITION     = 4'd4,
    CLS_DELETED      = 4'd5,
    CLS_ADDED        = 4'd6,
    CLS_CHANGED      = 4'd7,
    CLS_PATCH_ADD    = 4'd8,
    CLS_PATCH_DEL    = 4'd9,
    CLS_RM_PATCH_ADD = 4'd10,
    CLS_RM_PATCH_DEL = 4'd11
  } line_class_t;

  // one classified line travelling from front to back
  typedef struct packed {
    line_class_t cls;
    logic        pos_header;  // position line not starting with '-'
  } line_item_t;

endpackage

/* design/dlcf_front.sv */
// byte scanner and line classifier
module dlcf_front
  import dlcf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       in_last_of_line,
  input  logic       in_empty_line,
  output logic       push,
  output line_item_t push_item
);

  typedef enum logic [1:0] {
    NUM_SKIP,
    NUM_SIGN,
    NUM_DIGITS,
    NUM_DONE
  } num_phase_t;

  logic [CNT_W-1:0]                cnt_r, cnt_nxt;
  logic [PREFIX_DEPTH-1:0][7:0]    pfx_r, pfx_nxt;
  logic                            slash_r, slash_nxt;
  logic                            zero_r, zero_nxt;
  num_phase_t                      phase_r, phase_nxt;
  logic                            nonzero_r, nonzero_nxt;
  logic                            accept;
  logic                            line_end;
  logic                            ch_digit;
  logic                            ch_blank;

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= "0") && (c <= "9");
  endfunction

  function automatic line_class_t classify(input logic [PREFIX_DEPTH-1:0][7:0] p,
                                           input logic numbered);
    logic [7:0] b0;
    logic [7:0] b3;
    b0 = p[0];
    b3 = p[3];
    priority if ({p[0], p[1], p[2], p[3], p[4]} == "diff ") classify = CLS_COMMAND;
    else if ({p[0], p[1], p[2], p[3], p[4], p[5], p[6]} == "Index: ")
      classify = CLS_COMMAND;
    else if ({p[0], p[1], p[2]} == "---" && b3 != "-") begin
      priority if (b3 == " " && numbered) classify = CLS_POSITION;
      else if (b3 == 8'h0D || b3 == 8'h0A) classify = CLS_POSITION;
      else if (b3 == " ") classify = CLS_HEADER;
      else classify = CLS_DELETED;
    end
    else if ({p[0], p[1], p[2], p[3]} == "+++ ")
      classify = numbered ? CLS_POSITION : CLS_HEADER;
    else if ({p[0], p[1], p[2], p[3]} == "====") classify = CLS_HEADER;
    else if ({p[0], p[1], p[2]} == "***") begin
      priority if (b3 == " " && numbered) classify = CLS_POSITION;
      else if (b3 == "*") classify = CLS_POSITION;
      else classify = CLS_HEADER;
    end
    else if ({p[0], p[1]} == "? ") classify = CLS_HEADER;
    else if (b0 == "@") classify = CLS_POSITION;
    else if (is_digit(b0)) classify = CLS_POSITION;
    else if ({p[0], p[1]} == "++") classify = CLS_PATCH_ADD;
    else if ({p[0], p[1]} == "+-") classify = CLS_PATCH_DEL;
    else if ({p[0], p[1]} == "-+") classify = CLS_RM_PATCH_ADD;
    else if ({p[0], p[1]} == "--") classify = CLS_RM_PATCH_DEL;
    else if (b0 == "-" || b0 == "<") classify = CLS_DELETED;
    else if (b0 == "+" || b0 == ">") classify = CLS_ADDED;
    else if (b0 == "!") classify = CLS_CHANGED;
    else if (b0 != " ") classify = CLS_COMMENT;
    else classify = CLS_DEFAULT;
  endfunction

  assign accept   = in_valid && in_ready;
  assign line_end = accept && (in_last_of_line || in_empty_line);
  assign ch_digit = is_digit(in_ch);
  assign ch_blank = (in_ch == " ") || (in_ch >= 8'd9 && in_ch <= 8'd13);

  always_comb begin
    cnt_nxt     = cnt_r;
    pfx_nxt     = pfx_r;
    slash_nxt   = slash_r;
    zero_nxt    = zero_r;
    phase_nxt   = phase_r;
    nonzero_nxt = nonzero_r;
    if (!in_empty_line && !zero_r && cnt_r < CNT_W'(LINE_PREFIX_BYTES - 1)) begin
      if (in_ch == 8'd0) begin
        zero_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r < CNT_W'(PREFIX_DEPTH)) begin
          pfx_nxt[cnt_r[PFX_IDX_W-1:0]] = in_ch;
        end
        if (in_ch == "/") begin
          slash_nxt = 1'b1;
        end
        if (cnt_r >= CNT_W'(NUM_START_POS)) begin
          unique case (phase_r)
            NUM_SKIP: begin
              priority if (ch_blank) phase_nxt = NUM_SKIP;
              else if (in_ch == "+" || in_ch == "-") phase_nxt = NUM_SIGN;
              else if (ch_digit) begin
                phase_nxt = NUM_DIGITS;
                if (in_ch != "0") nonzero_nxt = 1'b1;
              end
              else phase_nxt = NUM_DONE;
            end
            NUM_SIGN, NUM_DIGITS: begin
              if (ch_digit) begin
                phase_nxt = NUM_DIGITS;
                if (in_ch != "0") nonzero_nxt = 1'b1;
              end else begin
                phase_nxt = NUM_DONE;
              end
            end
            NUM_DONE: phase_nxt = NUM_DONE;
          endcase
        end
      end
    end
  end

  // classify from the state including the line's final byte
  always_comb begin
    push                 = line_end;
    push_item.cls        = classify(pfx_nxt, nonzero_nxt && !slash_nxt);
    push_item.pos_header = (push_item.cls == CLS_POSITION) && (pfx_nxt[0] != "-");
  end

  always_ff @(posedge clk) begin
    if (!rst_n || line_end) begin
      cnt_r     <= '0;
      pfx_r     <= '0;
      slash_r   <= 1'b0;
      zero_r    <= 1'b0;
      phase_r   <= NUM_SKIP;
      nonzero_r <= 1'b0;
    end else if (accept) begin
      cnt_r     <= cnt_nxt;
      pfx_r     <= pfx_nxt;
      slash_r   <= slash_nxt;
      zero_r    <= zero_nxt;
      phase_r   <= phase_nxt;
      nonzero_r <= nonzero_nxt;
    end
  end

endmodule

/* design/dlcf_queue.sv */
// short queue of classified lines between front and back
module dlcf_queue
  import dlcf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  line_item_t push_item,
  output logic       full,
  output logic       q_valid,
  output line_item_t q_item,
  input  logic       pop
);

  line_item_t           mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r;
  logic                 do_push;
  logic                 do_pop;

  assign full    = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

/* design/dlcf_back.sv */
// fold level tracker, configuration registers and result register
module dlcf_back
  import dlcf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [LEVEL_W-1:0]     cfg_data,
  input  logic                   q_valid,
  input  line_item_t             q_item,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [3:0]             out_line_class,
  output logic [LEVEL_W-1:0]     out_fold_level,
  output logic                   out_fold_valid,
  output logic                   out_fix_previous,
  output logic [LEVEL_W-1:0]     out_previous_level
);

  logic               fold_en_r;
  logic [LEVEL_W-1:0] last_level_r;
  logic [LEVEL_W-1:0] next_level;
  logic               fix_prev;
  logic               out_valid_r;
  logic [3:0]         cls_r;
  logic [LEVEL_W-1:0] level_r;
  logic               fold_valid_r;
  logic               fix_r;
  logic [LEVEL_W-1:0] prev_level_r;

  assign pop = q_valid && (!out_valid_r || out_ready);

  always_comb begin
    priority if (q_item.cls == CLS_COMMAND) next_level = LEVEL_BASE | LEVEL_HEADER;
    else if (q_item.cls == CLS_HEADER) next_level = (LEVEL_BASE + 14'd1) | LEVEL_HEADER;
    else if (q_item.pos_header) next_level = (LEVEL_BASE + 14'd2) | LEVEL_HEADER;
    else if ((last_level_r & LEVEL_HEADER) != '0)
      next_level = (last_level_r & LEVEL_NUMBER) + 14'd1;
    else next_level = last_level_r;
    fix_prev = ((next_level & LEVEL_HEADER) != '0) && (next_level == last_level_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_en_r    <= 1'b0;
      last_level_r <= LEVEL_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_FOLD_ENABLE: fold_en_r    <= cfg_data[0];
          CFG_START_LEVEL: last_level_r <= cfg_data;
        endcase
      end
      if (pop) begin
        out_valid_r <= 1'b1;
        if (fold_en_r) begin
          last_level_r <= next_level;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cls_r        <= q_item.cls;
      fold_valid_r <= fold_en_r;
      level_r      <= fold_en_r ? next_level : '0;
      fix_r        <= fold_en_r && fix_prev;
      prev_level_r <= (fold_en_r && fix_prev) ? (last_level_r & ~LEVEL_HEADER) : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_line_class     = cls_r;
  assign out_fold_level     = level_r;
  assign out_fold_valid     = fold_valid_r;
  assign out_fix_previous   = fix_r;
  assign out_previous_level = prev_level_r;

endmodule

/* design/diff_line_classifier_folder.sv */
// top level of the diff line classifier with fold levels
//
//  channel | ports                                            | request moves
//  --------+--------------------------------------------------+--------------------------
//  in      | in_valid in_ready in_ch in_last_of_line          | one byte of a line
//          | in_empty_line                                    |
//  out     | out_valid out_ready out_line_class out_fold_*    | one result per line end
//          | out_fix_previous out_previous_level              |
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data           | one register write
//
//  one byte per cycle sustained while in_ready is high; a line end's result is registered
//  on its way out, first into the queue, then into the result register
//  the back part updates its last fold level on each pop, so lines follow back to back
//  a stalled result leaves room for two more lines in the queue before in_ready drops
//  reset (rst_n low, synchronous) clears line state, queue, result valid and registers
//  cfg_ready is always high; writes are meant for an idle block
module diff_line_classifier_folder
  import dlcf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_ch,
  input  logic                   in_last_of_line,
  input  logic                   in_empty_line,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [3:0]             out_line_class,
  output logic [LEVEL_W-1:0]     out_fold_level,
  output logic                   out_fold_valid,
  output logic                   out_fix_previous,
  output logic [LEVEL_W-1:0]     out_previous_level,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [LEVEL_W-1:0]     cfg_data
);

  logic       push;
  line_item_t push_item;
  logic       q_full;
  logic       q_valid;
  line_item_t q_item;
  logic       pop;

  // bytes are taken whenever the queue has room for a finished line
  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;

  // front: per-byte flags, prefix capture, number scan, class at line end
  dlcf_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_ch           (in_ch),
    .in_last_of_line (in_last_of_line),
    .in_empty_line   (in_empty_line),
    .push            (push),
    .push_item       (push_item)
  );

  // queue decouples classifier from the result side
  dlcf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop)
  );

  // back: fold level from class and previous level, result register
  dlcf_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_line_class     (out_line_class),
    .out_fold_level     (out_fold_level),
    .out_fold_valid     (out_fold_valid),
    .out_fix_previous   (out_fix_previous),
    .out_previous_level (out_previous_level)
  );

endmodule

/* design/dlcf_checker.sv */
// port level checks of the diff line classifier, bound to the top level
module dlcf_checker
  import dlcf_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [3:0]         out_line_class,
  input logic [LEVEL_W-1:0] out_fold_level,
  input logic               out_fold_valid,
  input logic               out_fix_previous,
  input logic [LEVEL_W-1:0] out_previous_level
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_line_class)
      && $stable(out_fold_level))
    else $error("result changed while stalled");

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // folding off leaves all fold fields zero
  a_fold_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fold_valid |-> out_fold_level == '0 && !out_fix_previous
      && out_previous_level == '0)
    else $error("fold fields set while folding off");

  // a fix always carries a header level and its unflagged copy
  a_fix_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fix_previous |-> out_fold_level[13]
      && out_previous_level == (out_fold_level & ~LEVEL_HEADER))
    else $error("previous level does not match header level");

  // command lines open a base level header
  a_command_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fold_valid && out_line_class == CLS_COMMAND
      |-> out_fold_level == (LEVEL_BASE | LEVEL_HEADER))
    else $error("command line level wrong");

endmodule

bind diff_line_classifier_folder dlcf_checker u_dlcf_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_line_class     (out_line_class),
  .out_fold_level     (out_fold_level),
  .out_fold_valid     (out_fold_valid),
  .out_fix_previous   (out_fix_previous),
  .out_previous_level (out_previous_level)
);

/* bench/tb.sv */
// self-checking bench for the diff line classifier with fold levels
module tb;
  import dlcf_pkg::*;

  // ascii codes the line rules look at
  localparam byte unsigned TAB = 8'h09;
  localparam byte unsigned LF  = 8'h0A;
  localparam byte unsigned VT  = 8'h0B;
  localparam byte unsigned FF  = 8'h0C;
  localparam byte unsigned CR  = 8'h0D;

  localparam int PLAN_ROWS = 36;

  // where the atoi-style scan from position 4 stands
  typedef enum logic [1:0] {
    NUM_SKIP,    // skipping leading blanks
    NUM_SIGN,    // sign taken, digits may follow
    NUM_DIGITS,  // inside the digit run
    NUM_DONE     // scan over
  } num_phase_t;

  // receiver back-pressure patterns
  typedef enum logic [1:0] {
    RX_OPEN,     // always ready
    RX_SPOTTY,   // random stalls
    RX_TRICKLE,  // ready one cycle in eight
    RX_BLOCKY    // alternating ready and stalled runs of equal length
  } rx_mode_t;

  typedef struct {
    line_class_t      cls;
    logic [LEVEL_W-1:0] level;
    logic             lvl_ok;
    logic             fix;
    logic [LEVEL_W-1:0] prev_level;
  } line_result_t;

  // one directed step: either a whole line or a register write
  typedef struct {
    string                  text;
    int                     zero_at;   // byte replaced by zero, -1 for none
    bit                     open_end;  // line closed by an empty-line request
    bit                     typed;     // class written out below
    line_class_t            want;
    bit                     is_cfg;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [LEVEL_W-1:0]     reg_val;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [7:0]             in_ch;
  logic                   in_last_of_line;
  logic                   in_empty_line;
  logic                   out_valid;
  logic                   out_ready;
  logic [3:0]             out_line_class;
  logic [LEVEL_W-1:0]     out_fold_level;
  logic                   out_fold_valid;
  logic                   out_fix_previous;
  logic [LEVEL_W-1:0]     out_previous_level;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [LEVEL_W-1:0]     cfg_data;

  // predictor copy of the block state and registers
  int                 line_bytes;
  byte unsigned       pfx [PREFIX_DEPTH];
  bit                 slash_hit;
  bit                 zero_hit;
  num_phase_t         num_state;
  bit                 num_nonzero;
  bit                 fold_on;
  logic [LEVEL_W-1:0] start_lvl;
  logic [LEVEL_W-1:0] last_lvl;

  line_result_t pending_lines[$];
  byte unsigned line_buf[$];
  int           mismatch_count = 0;
  int           burst_left = 0;
  int           items_sent = 0;
  int unsigned  stall_tick = 0;
  rx_mode_t     rx_mode = RX_OPEN;

  // first bytes of plausible diff lines; the first ten are the header kinds
  string line_heads [25] = '{
    "diff ", "Index: ", "--- ", "+++ ", "*** ", "---", "***", "====", "? ", "@@ ",
    "++", "+-", "-+", "--", "-", "+", "<", ">", "!", " ", "1", "0", "x", "Inde", "dif"
  };

  // directed lines, class typed in where the prefix rule is plain
  plan_row_t plan [PLAN_ROWS] = '{
    '{"x\n",           -1, 0, 1, CLS_COMMENT,      0, CFG_FOLD_ENABLE, '0},
    '{"",              -1, 0, 0, CLS_DEFAULT,      1, CFG_FOLD_ENABLE, 14'h0001},
    '{"",              -1, 0, 0, CLS_DEFAULT,      1, CFG_START_LEVEL, 14'h2400},
    '{"diff a\n",      -1, 0, 1, CLS_COMMAND,      0, CFG_FOLD_ENABLE, '0},
    '{"Index: f\n",    -1, 0, 1, CLS_COMMAND,      0, CFG_FOLD_ENABLE, '0},
    '{"--- 12,3\n",    -1, 0, 1, CLS_POSITION,     0, CFG_FOLD_ENABLE, '0},
    '{"--- a/b/c\n",   -1, 0, 1, CLS_HEADER,       0, CFG_FOLD_ENABLE, '0},
    '{"---\n",         -1, 0, 1, CLS_POSITION,     0, CFG_FOLD_ENABLE, '0},
    '{"---x\n",        -1, 0, 1, CLS_DELETED,      0, CFG_FOLD_ENABLE, '0},
    '{"+++ +7\n",      -1, 0, 1, CLS_POSITION,     0, CFG_FOLD_ENABLE, '0},
    '{"+++ -0 b/x\n",  -1, 0, 1, CLS_HEADER,       0, CFG_FOLD_ENABLE, '0},
    '{"====\n",        -1, 0, 1, CLS_HEADER,       0, CFG_FOLD_ENABLE, '0},
    '{"*** \t9\n",     -1, 0, 1, CLS_POSITION,     0, CFG_FOLD_ENABLE, '0},
    '{"****\n",        -1, 0, 1, CLS_POSITION,     0, CFG_FOLD_ENABLE, '0},
    '{"*** old/f\n",   -1, 0, 1, CLS_HEADER,       0, CFG_FOLD_ENABLE, '0},
    '{"? q\n",         -1, 0, 1, CLS_HEADER,       0, CFG_FOLD_ENABLE, '0},
    '{"@@ -1 +1 @@\n", -1, 0, 1, CLS_POSITION,     0, CFG_FOLD_ENABLE, '0},
    '{"7c7\n",         -1, 0, 1, CLS_POSITION,     0, CFG_FOLD_ENABLE, '0},
    '{"++a\n",         -1, 0, 1, CLS_PATCH_ADD,    0, CFG_FOLD_ENABLE, '0},
    '{"+-a\n",         -1, 0, 1, CLS_PATCH_DEL,    0, CFG_FOLD_ENABLE, '0},
    '{"-+a\n",         -1, 0, 1, CLS_RM_PATCH_ADD, 0, CFG_FOLD_ENABLE, '0},
    '{"--a\n",         -1, 0, 1, CLS_RM_PATCH_DEL, 0, CFG_FOLD_ENABLE, '0},
    '{"-a\n",          -1, 0, 1, CLS_DELETED,      0, CFG_FOLD_ENABLE, '0},
    '{"<a\n",          -1, 0, 1, CLS_DELETED,      0, CFG_FOLD_ENABLE, '0},
    '{"+a\n",          -1, 0, 1, CLS_ADDED,        0, CFG_FOLD_ENABLE, '0},
    '{">a\n",          -1, 0, 1, CLS_ADDED,        0, CFG_FOLD_ENABLE, '0},
    '{"!a\n",          -1, 0, 1, CLS_CHANGED,      0, CFG_FOLD_ENABLE, '0},
    '{" a\n",          -1, 0, 1, CLS_DEFAULT,      0, CFG_FOLD_ENABLE, '0},
    '{"",              -1, 0, 1, CLS_COMMENT,      0, CFG_FOLD_ENABLE, '0},
    '{"+++ 5\n",        4, 0, 1, CLS_HEADER,       0, CFG_FOLD_ENABLE, '0},
    '{"***            9\n", -1, 0, 1, CLS_HEADER,  0, CFG_FOLD_ENABLE, '0},
    '{"+++ 3",         -1, 1, 1, CLS_POSITION,     0, CFG_FOLD_ENABLE, '0},
    '{"",              -1, 0, 0, CLS_DEFAULT,      1, CFG_START_LEVEL, 14'h3FFF},
    '{" a\n",          -1, 0, 0, CLS_DEFAULT,      0, CFG_FOLD_ENABLE, '0},
    '{"",              -1, 0, 0, CLS_DEFAULT,      1, CFG_START_LEVEL, 14'h0000},
    '{"",              -1, 0, 0, CLS_DEFAULT,      1, CFG_FOLD_ENABLE, 14'h0000}
  };

  diff_line_classifier_folder DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_ch              (in_ch),
    .in_last_of_line    (in_last_of_line),
    .in_empty_line      (in_empty_line),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_line_class     (out_line_class),
    .out_fold_level     (out_fold_level),
    .out_fold_valid     (out_fold_valid),
    .out_fix_previous   (out_fix_previous),
    .out_previous_level (out_previous_level),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_line_state();
    line_bytes  = 0;
    foreach (pfx[i]) pfx[i] = 8'h00;
    slash_hit   = 1'b0;
    zero_hit    = 1'b0;
    num_state   = NUM_SKIP;
    num_nonzero = 1'b0;
  endfunction

  function automatic bit is_digit(byte unsigned c);
    return c >= "0" && c <= "9";
  endfunction

  // one usable byte of the line: prefix, slash flag and number scan
  function automatic void scan_byte(byte unsigned c);
    int pos;
    pos = line_bytes;
    if (zero_hit || pos >= LINE_PREFIX_BYTES - 1) return;
    if (c == 8'h00) begin
      zero_hit = 1'b1;
      return;
    end
    line_bytes = pos + 1;
    if (pos < PREFIX_DEPTH) pfx[pos] = c;
    if (c == "/") slash_hit = 1'b1;
    if (pos >= NUM_START_POS) begin
      case (num_state)
        NUM_SKIP: begin
          // blanks keep the scan waiting
          if (!(c == " " || (c >= TAB && c <= CR))) begin
            if (c == "+" || c == "-") begin
              num_state = NUM_SIGN;
            end else if (is_digit(c)) begin
              num_state = NUM_DIGITS;
              if (c != "0") num_nonzero = 1'b1;
            end else begin
              num_state = NUM_DONE;
            end
          end
        end
        NUM_SIGN, NUM_DIGITS: begin
          if (is_digit(c)) begin
            num_state = NUM_DIGITS;
            if (c != "0") num_nonzero = 1'b1;
          end else begin
            num_state = NUM_DONE;
          end
        end
        default: ;
      endcase
    end
  endfunction

  function automatic bit has_prefix(string s);
    for (int i = 0; i < s.len() && i < PREFIX_DEPTH; i++)
      if (pfx[i] != s[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic line_class_t classify_line();
    byte unsigned b0, b3;
    bit           numbered;
    b0 = pfx[0];
    b3 = pfx[3];
    numbered = num_nonzero && !slash_hit;
    if (has_prefix("diff ") || has_prefix("Index: ")) return CLS_COMMAND;
    if (has_prefix("---") && b3 != "-") begin
      if (b3 == " " && numbered) return CLS_POSITION;
      if (b3 == CR || b3 == LF) return CLS_POSITION;
      if (b3 == " ") return CLS_HEADER;
      return CLS_DELETED;
    end
    if (has_prefix("+++ ")) begin
      if (numbered) return CLS_POSITION;
      return CLS_HEADER;
    end
    if (has_prefix("====")) return CLS_HEADER;
    if (has_prefix("***")) begin
      if ((b3 == " " && numbered) || b3 == "*") return CLS_POSITION;
      return CLS_HEADER;
    end
    if (has_prefix("? ")) return CLS_HEADER;
    if (b0 == "@" || is_digit(b0)) return CLS_POSITION;
    if (has_prefix("++")) return CLS_PATCH_ADD;
    if (has_prefix("+-")) return CLS_PATCH_DEL;
    if (has_prefix("-+")) return CLS_RM_PATCH_ADD;
    if (has_prefix("--")) return CLS_RM_PATCH_DEL;
    if (b0 == "-" || b0 == "<") return CLS_DELETED;
    if (b0 == "+" || b0 == ">") return CLS_ADDED;
    if (b0 == "!") return CLS_CHANGED;
    if (b0 != " ") return CLS_COMMENT;
    return CLS_DEFAULT;
  endfunction

  // line end: class, then the fold level chained from the previous line
  function automatic line_result_t close_line();
    line_result_t       r;
    logic [LEVEL_W-1:0] prev_lvl, nxt_lvl;
    r.cls        = classify_line();
    r.level      = '0;
    r.lvl_ok     = 1'b0;
    r.fix        = 1'b0;
    r.prev_level = '0;
    if (fold_on) begin
      prev_lvl = last_lvl;
      if (r.cls == CLS_COMMAND)
        nxt_lvl = LEVEL_BASE | LEVEL_HEADER;
      else if (r.cls == CLS_HEADER)
        nxt_lvl = (LEVEL_BASE + 14'd1) | LEVEL_HEADER;
      else if (r.cls == CLS_POSITION && pfx[0] != "-")
        nxt_lvl = (LEVEL_BASE + 14'd2) | LEVEL_HEADER;
      else if ((prev_lvl & LEVEL_HEADER) != '0)
        nxt_lvl = (prev_lvl & LEVEL_NUMBER) + 14'd1;
      else
        nxt_lvl = prev_lvl;
      r.level  = nxt_lvl;
      r.lvl_ok = 1'b1;
      // same header level twice: previous line loses its header flag
      if ((nxt_lvl & LEVEL_HEADER) != '0 && nxt_lvl == prev_lvl) begin
        r.fix        = 1'b1;
        r.prev_level = prev_lvl & ~LEVEL_HEADER;
      end
      last_lvl = nxt_lvl;
    end
    clear_line_state();
    return r;
  endfunction

  function automatic void predict_item(byte unsigned c, bit is_last, bit is_empty,
                                       bit typed, line_class_t want);
    line_result_t r;
    if (!is_empty) scan_byte(c);
    if (is_last || is_empty) begin
      r = close_line();
      if (typed) r.cls = want;
      pending_lines.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic report_mismatch(string what);
    if (mismatch_count < 40) $display("%0t mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // one byte request; the sender may idle between bursts of random length
  task automatic push_byte(byte unsigned c, bit is_last, bit is_empty,
                           bit typed, line_class_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    in_valid        <= 1'b1;
    in_ch           <= c;
    in_last_of_line <= is_last;
    in_empty_line   <= is_empty;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    items_sent++;
    predict_item(c, is_last, is_empty, typed, want);
  endtask

  // sends line_buf; an empty buffer becomes a single empty-line request
  task automatic send_line(bit open_end, bit typed, line_class_t want);
    int n;
    n = line_buf.size();
    if (n == 0) begin
      push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, typed, want);
    end else begin
      for (int i = 0; i < n; i++)
        push_byte(line_buf[i], (i == n - 1) && !open_end, 1'b0,
                  typed && (i == n - 1) && !open_end, want);
      // open line closed by the empty-line flag, whatever last says
      if (open_end)
        push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, typed, want);
    end
  endtask

  // sender holds off until every line result is back
  task automatic drain_lines();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_lines.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [LEVEL_W-1:0] value);
    drain_lines();
    // two-stage result path: let it settle before touching registers
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_FOLD_ENABLE) begin
      fold_on = value[0];
    end else begin
      start_lvl = value;
      last_lvl  = value;
    end
  endtask

  // random line: mostly diff-shaped, some raw noise and empty lines
  function automatic bit make_line();
    int    kind, n;
    string head;
    line_buf.delete();
    kind = $urandom_range(0, 99);
    if (kind < 5) return 1'b0;
    if (kind < 13) begin
      n = $urandom_range(1, 20);
      repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
      return $urandom_range(0, 9) == 0;
    end
    head = (kind < 65) ? line_heads[$urandom_range(0, 9)] : line_heads[$urandom_range(0, 24)];
    for (int i = 0; i < head.len(); i++) line_buf.push_back(head[i]);
    // probe the fourth-byte cases after three-char heads
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 4))
        0:       line_buf.push_back("-");
        1:       line_buf.push_back("*");
        2:       line_buf.push_back(" ");
        3:       line_buf.push_back(CR);
        default: line_buf.push_back(LF);
      endcase
    end
    // blanks, optional sign and a digit run for the number scan
    if ($urandom_range(0, 1) == 1) begin
      repeat ($urandom_range(0, 2)) begin
        case ($urandom_range(0, 5))
          0:       line_buf.push_back(" ");
          1:       line_buf.push_back(TAB);
          2:       line_buf.push_back(LF);
          3:       line_buf.push_back(VT);
          4:       line_buf.push_back(FF);
          default: line_buf.push_back(CR);
        endcase
      end
      if ($urandom_range(0, 2) == 0) line_buf.push_back($urandom_range(0, 1) ? "+" : "-");
      repeat ($urandom_range(1, 4))
        line_buf.push_back($urandom_range(0, 1) ? "0" : 8'("0" + $urandom_range(0, 9)));
    end
    repeat ($urandom_range(0, 8)) begin
      case ($urandom_range(0, 5))
        0:       line_buf.push_back("/");
        1:       line_buf.push_back(",");
        2:       line_buf.push_back(8'("0" + $urandom_range(0, 9)));
        3:       line_buf.push_back("-");
        4:       line_buf.push_back(" ");
        default: line_buf.push_back(8'("a" + $urandom_range(0, 25)));
      endcase
    end
    if ($urandom_range(0, 19) == 0) line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'h00;
    case ($urandom_range(0, 9))
      0, 1: ;  // no terminator
      2: begin
        line_buf.push_back(CR);
        line_buf.push_back(LF);
      end
      default: line_buf.push_back(LF);
    endcase
    return $urandom_range(0, 9) == 0;
  endfunction

  // ---------------------------------------------------------------- receiver

  // back-pressure pattern is redrawn at random on a tick counter
  always @(posedge clk) begin
    if (stall_tick % 64 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:    out_ready <= 1'b1;
      RX_SPOTTY:  out_ready <= ($urandom_range(0, 3) != 0);
      RX_TRICKLE: out_ready <= (stall_tick % 8 == 7);
      default:    out_ready <= ((stall_tick / 8) % 2 == 0);
    endcase
    stall_tick++;
  end

  // every accepted result against the oldest pending line
  always @(posedge clk) begin : result_check
    line_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_lines.size() == 0) begin
        report_mismatch($sformatf("result with no line pending, class %0d", out_line_class));
      end else begin
        want = pending_lines.pop_front();
        if (out_line_class !== want.cls)
          report_mismatch($sformatf("line_class got %0d want %0d", out_line_class, want.cls));
        if (out_fold_level !== want.level)
          report_mismatch($sformatf("fold_level got %h want %h", out_fold_level, want.level));
        if (out_fold_valid !== want.lvl_ok)
          report_mismatch($sformatf("fold_valid got %b want %b", out_fold_valid, want.lvl_ok));
        if (out_fix_previous !== want.fix)
          report_mismatch($sformatf("fix_previous got %b want %b", out_fix_previous, want.fix));
        if (out_previous_level !== want.prev_level)
          report_mismatch($sformatf("previous_level got %h want %h",
                                    out_previous_level, want.prev_level));
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int phase_start;
    bit open_end;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_ch           <= '0;
    in_last_of_line <= 1'b0;
    in_empty_line   <= 1'b0;
    cfg_valid       <= 1'b0;
    cfg_index       <= CFG_FOLD_ENABLE;
    cfg_data        <= '0;
    fold_on   = 1'b0;
    start_lvl = LEVEL_RESET;
    last_lvl  = LEVEL_RESET;
    clear_line_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed lines and register writes, reset values first
    foreach (plan[r]) begin
      if (plan[r].is_cfg) begin
        write_register(plan[r].reg_idx, plan[r].reg_val);
      end else begin
        line_buf.delete();
        for (int i = 0; i < plan[r].text.len(); i++)
          line_buf.push_back((i == plan[r].zero_at) ? 8'h00 : plan[r].text[i]);
        send_line(plan[r].open_end, plan[r].typed, plan[r].want);
      end
    end

    // random lines under several register settings, extremes included
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       write_register(CFG_START_LEVEL, 14'h0000);
        1:       write_register(CFG_START_LEVEL, LEVEL_BASE | LEVEL_HEADER);
        2:       write_register(CFG_START_LEVEL, 14'h3FFF);
        5:       write_register(CFG_START_LEVEL, LEVEL_HEADER | 14'($urandom_range(0, 8191)));
        default: write_register(CFG_START_LEVEL, 14'($urandom_range(0, 16383)));
      endcase
      // fold enable in bit 0, junk above it
      write_register(CFG_FOLD_ENABLE,
                     {13'($urandom_range(0, 8191)), (p == 3) ? 1'b0 : 1'b1});
      phase_start = items_sent;
      while (items_sent - phase_start < 140) begin
        open_end = make_line();
        send_line(open_end, 1'b0, CLS_DEFAULT);
        if ($urandom_range(0, 29) == 0) drain_lines();
      end
    end

    drain_lines();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
